>>> design/stu_pkg.sv
// Shared types, constants and keyword tables for the source tokenizer.
`timescale 1ns / 1ps

package stu_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int LINE_WIDTH   = 24;
  localparam int KW_COUNT     = 12;
  localparam int KW_MAX_LEN   = 6;

  typedef logic [5:0]              kind_t;
  typedef logic [LENGTH_WIDTH-1:0] len_t;
  typedef logic [LINE_WIDTH-1:0]   line_t;
  typedef logic [KW_COUNT-1:0]     cand_t;

  localparam kind_t KIND_COMMA  = 6'd0;
  localparam kind_t KIND_LBRACE = 6'd1;
  localparam kind_t KIND_RBRACE = 6'd2;
  localparam kind_t KIND_LPAREN = 6'd3;
  localparam kind_t KIND_RPAREN = 6'd4;
  localparam kind_t KIND_COLON  = 6'd7;
  localparam kind_t KIND_SEMI   = 6'd8;
  localparam kind_t KIND_STAR   = 6'd19;
  localparam kind_t KIND_SLASH  = 6'd20;
  localparam kind_t KIND_STRING = 6'd21;
  localparam kind_t KIND_INT    = 6'd22;
  localparam kind_t KIND_POINT  = 6'd23;
  localparam kind_t KIND_IDENT  = 6'd24;
  localparam kind_t KIND_KW0    = 6'd25;
  localparam kind_t KIND_END    = 6'd37;
  localparam kind_t KIND_ERROR  = 6'd38;

  localparam logic [2:0] PEND_EQ    = 3'd0;
  localparam logic [2:0] PEND_BANG  = 3'd1;
  localparam logic [2:0] PEND_LT    = 3'd2;
  localparam logic [2:0] PEND_GT    = 3'd3;
  localparam logic [2:0] PEND_PLUS  = 3'd4;
  localparam logic [2:0] PEND_MINUS = 3'd5;

  localparam cand_t KW_ALL = '1;
  localparam len_t  LEN_MAX  = '1;
  localparam line_t LINE_MAX = '1;

  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    {"void", 16'h0}, {"bool", 16'h0}, {"char", 16'h0}, "string",
    {"i32", 24'h0}, {"i64", 24'h0}, {"f32", 24'h0}, {"f64", 24'h0},
    "return", {"true", 16'h0}, {"false", 8'h0}, {"call", 16'h0}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd4, 3'd4, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd6, 3'd4, 3'd5, 3'd4
  };

  localparam logic [7:0] OP_CHAR [8] = '{"=", "!", "<", ">", "+", "-", "=", "="};
  localparam kind_t OP_SINGLE [8] = '{6'd5, 6'd9, 6'd11, 6'd13, 6'd15, 6'd17, 6'd5, 6'd5};
  localparam kind_t OP_PAIR [8]   = '{6'd6, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd6, 6'd6};

  // One result word as it waits in the output queue.
  typedef struct packed {
    kind_t kind;
    len_t  length;
    line_t line;
    logic  last;
  } tok_t;

  // Keeps the keywords whose character at position pos equals b.
  function automatic cand_t kw_filter(cand_t cand, len_t pos, logic [7:0] b);
    cand_t      res;
    logic [2:0] p;
    res = '0;
    p   = pos[2:0];
    if (pos < len_t'(KW_MAX_LEN)) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (cand[k] && (p < KW_LEN[k]) &&
            (KW_TEXT[k][8*(KW_MAX_LEN-1-int'(p)) +: 8] == b)) begin
          res[k] = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

>>> design/stu_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps

interface stu_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, byte_in, end_of_input, input ready);
  modport sink (input valid, byte_in, end_of_input, output ready);
endinterface

interface stu_tok_if import stu_pkg::*;;
  logic  valid;
  logic  ready;
  kind_t token_kind;
  len_t  token_length;
  line_t line_number;
  logic  last_of_run;

  modport source (output valid, token_kind, token_length, line_number, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, token_length, line_number, last_of_run,
                output ready);
endinterface

>>> design/source_tokenizer_unit.sv
// Byte-serial tokenizer with a four-word token queue on its output.
//
// Channel  Dir  Word
// chr_i    in   byte_in[7:0], end_of_input
// tok_o    out  token_kind[5:0], token_length[15:0], line_number[23:0], last_of_run
//
// Each accepted byte updates the scanner state and pushes zero, one or
// two tokens into the output queue in the same cycle.
// A byte is taken whenever at most two queue entries are occupied, so one byte per
// cycle is sustained while tokens drain as fast as they are made.
// Reset returns the scanner to idle on line one and empties the queue.
// A stalled output holds its word; input stalls once the queue cannot take two more.
`timescale 1ns / 1ps

module source_tokenizer_unit import stu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  stu_chr_if.sink       chr_i,
  stu_tok_if.source     tok_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_OP,
    MODE_STR,
    MODE_NUM,
    MODE_ID
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       dot_q, dot_d;
  len_t       len_q, len_d;
  line_t      line_q, line_d;
  cand_t      cand_q, cand_d;
  logic [2:0] pend_q, pend_d;

  tok_t       fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  logic [7:0] b;
  logic       take, pop;
  logic       is_digit, is_alpha, is_space, is_word;
  len_t       len_inc;

  mode_e      i_mode;
  logic [2:0] i_pend;
  len_t       i_len;
  cand_t      i_cand;
  logic       i_emit, i_nl;
  kind_t      i_kind;
  len_t       i_tlen;

  kind_t      w_kind;
  len_t       w_len;

  logic       f_v, s_v;
  kind_t      f_kind, s_kind;
  len_t       f_len, s_len;
  logic       a_v, b_v;
  tok_t       a_tok, b_tok;
  logic [1:0] push_n;

  assign b        = chr_i.byte_in;
  assign take     = chr_i.valid && chr_i.ready;
  assign pop      = tok_o.valid && tok_o.ready;
  assign is_digit = (b >= "0") && (b <= "9");
  assign is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  assign is_space = (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  assign is_word  = is_alpha || is_digit || (b == "_");
  assign len_inc  = (len_q < LEN_MAX) ? len_q + len_t'(1) : len_q;

  // What the byte does when it starts a fresh token.
  always_comb begin
    i_mode = MODE_IDLE;
    i_pend = 3'd0;
    i_len  = '0;
    i_cand = KW_ALL;
    i_emit = 1'b0;
    i_nl   = 1'b0;
    i_kind = KIND_ERROR;
    i_tlen = len_t'(1);
    case (b)
      ",":  begin i_emit = 1'b1; i_kind = KIND_COMMA;  end
      "{":  begin i_emit = 1'b1; i_kind = KIND_LBRACE; end
      "}":  begin i_emit = 1'b1; i_kind = KIND_RBRACE; end
      "(":  begin i_emit = 1'b1; i_kind = KIND_LPAREN; end
      ")":  begin i_emit = 1'b1; i_kind = KIND_RPAREN; end
      ":":  begin i_emit = 1'b1; i_kind = KIND_COLON;  end
      ";":  begin i_emit = 1'b1; i_kind = KIND_SEMI;   end
      "*":  begin i_emit = 1'b1; i_kind = KIND_STAR;   end
      "/":  begin i_emit = 1'b1; i_kind = KIND_SLASH;  end
      "=":  begin i_mode = MODE_OP; i_pend = PEND_EQ;    end
      "!":  begin i_mode = MODE_OP; i_pend = PEND_BANG;  end
      "<":  begin i_mode = MODE_OP; i_pend = PEND_LT;    end
      ">":  begin i_mode = MODE_OP; i_pend = PEND_GT;    end
      "+":  begin i_mode = MODE_OP; i_pend = PEND_PLUS;  end
      "-":  begin i_mode = MODE_OP; i_pend = PEND_MINUS; end
      "\"": begin i_mode = MODE_STR; i_len = len_t'(1); end
      default: begin
        if (is_space) begin
          i_nl = (b == 8'h0A);
        end else if (is_digit) begin
          i_mode = MODE_NUM;
          i_len  = len_t'(1);
        end else if (is_alpha) begin
          i_mode = MODE_ID;
          i_len  = len_t'(1);
          i_cand = kw_filter(KW_ALL, '0, b);
        end else begin
          i_emit = 1'b1;
          i_kind = KIND_ERROR;
          i_tlen = '0;
        end
      end
    endcase
  end

  // Token held in number or identifier mode, as it leaves on a flush.
  always_comb begin
    w_kind = KIND_IDENT;
    w_len  = len_q;
    if (mode_q == MODE_NUM) begin
      w_kind = dot_q ? KIND_POINT : KIND_INT;
      if (dot_q && pend_q[0] && (len_q < LEN_MAX)) begin
        w_len = len_q + len_t'(1);
      end
    end else begin
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (cand_q[k] && (len_q == len_t'(KW_LEN[k]))) begin
          w_kind = KIND_KW0 + kind_t'(k);
        end
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    dot_d  = dot_q;
    len_d  = len_q;
    line_d = line_q;
    cand_d = cand_q;
    pend_d = pend_q;
    f_v    = 1'b0;
    f_kind = w_kind;
    f_len  = w_len;
    s_v    = 1'b0;
    s_kind = i_kind;
    s_len  = i_tlen;
    if (chr_i.end_of_input) begin
      case (mode_q)
        MODE_OP: begin
          f_v    = 1'b1;
          f_kind = OP_SINGLE[pend_q];
          f_len  = len_t'(1);
        end
        MODE_STR: begin
          f_v    = 1'b1;
          f_kind = KIND_ERROR;
          f_len  = '0;
        end
        MODE_NUM, MODE_ID: f_v = 1'b1;
        default: f_v = 1'b0;
      endcase
      s_v    = 1'b1;
      s_kind = KIND_END;
      s_len  = '0;
      mode_d = MODE_IDLE;
      dot_d  = 1'b0;
      len_d  = '0;
      line_d = line_t'(1);
      cand_d = KW_ALL;
      pend_d = 3'd0;
    end else begin
      case (mode_q)
        MODE_OP: begin
          f_v = 1'b1;
          if (b == OP_CHAR[pend_q]) begin
            f_kind = OP_PAIR[pend_q];
            f_len  = len_t'(2);
            mode_d = MODE_IDLE;
            dot_d  = 1'b0;
            len_d  = '0;
            cand_d = KW_ALL;
            pend_d = 3'd0;
          end else begin
            f_kind = OP_SINGLE[pend_q];
            f_len  = len_t'(1);
            s_v    = i_emit;
            mode_d = i_mode;
            dot_d  = 1'b0;
            len_d  = i_len;
            cand_d = i_cand;
            pend_d = i_pend;
          end
        end
        MODE_STR: begin
          len_d = len_inc;
          if (b == "\"") begin
            f_v    = 1'b1;
            f_kind = KIND_STRING;
            f_len  = len_inc;
            mode_d = MODE_IDLE;
            dot_d  = 1'b0;
            len_d  = '0;
            cand_d = KW_ALL;
            pend_d = 3'd0;
          end
        end
        MODE_NUM, MODE_ID: begin
          if ((mode_q == MODE_NUM) && is_digit) begin
            len_d  = len_inc;
            pend_d = 3'd0;
          end else if ((mode_q == MODE_NUM) && (b == ".") && !dot_q) begin
            len_d  = len_inc;
            dot_d  = 1'b1;
            pend_d = 3'd1;
          end else if ((mode_q == MODE_ID) && is_word) begin
            cand_d = kw_filter(cand_q, len_q, b);
            len_d  = len_inc;
          end else begin
            f_v    = 1'b1;
            s_v    = i_emit;
            mode_d = i_mode;
            dot_d  = 1'b0;
            len_d  = i_len;
            cand_d = i_cand;
            pend_d = i_pend;
          end
        end
        default: begin
          s_v    = i_emit;
          mode_d = i_mode;
          dot_d  = 1'b0;
          len_d  = i_len;
          cand_d = i_cand;
          pend_d = i_pend;
        end
      endcase
      if (i_nl && (line_q < LINE_MAX) && (mode_d == MODE_IDLE) && (mode_q != MODE_STR)) begin
        line_d = line_q + line_t'(1);
      end
    end
  end

  // Packs the one or two tokens of this byte into consecutive queue words.
  always_comb begin
    a_v          = f_v || s_v;
    b_v          = f_v && s_v;
    a_tok.kind   = f_v ? f_kind : s_kind;
    a_tok.length = f_v ? f_len : s_len;
    a_tok.line   = line_q;
    a_tok.last   = !b_v;
    b_tok.kind   = s_kind;
    b_tok.length = s_len;
    b_tok.line   = line_q;
    b_tok.last   = 1'b1;
    push_n       = {1'b0, take && a_v} + {1'b0, take && b_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      dot_q  <= 1'b0;
      len_q  <= '0;
      line_q <= line_t'(1);
      cand_q <= KW_ALL;
      pend_q <= 3'd0;
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (take) begin
        mode_q <= mode_d;
        dot_q  <= dot_d;
        len_q  <= len_d;
        line_q <= line_d;
        cand_q <= cand_d;
        pend_q <= pend_d;
      end
      wp_q  <= wp_q + push_n;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && a_v) begin
      fifo_q[wp_q] <= a_tok;
    end
    if (take && b_v) begin
      fifo_q[wp_q + 2'd1] <= b_tok;
    end
  end

  assign chr_i.ready        = (cnt_q < 3'd3);
  assign tok_o.valid        = (cnt_q != 3'd0);
  assign tok_o.token_kind   = fifo_q[rp_q].kind;
  assign tok_o.token_length = fifo_q[rp_q].length;
  assign tok_o.line_number  = fifo_q[rp_q].line;
  assign tok_o.last_of_run  = fifo_q[rp_q].last;

endmodule

>>> design/stu_checker.sv
// Port-level assertions for the source tokenizer and their bind.
`timescale 1ns / 1ps

module stu_checker import stu_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input kind_t kind_i,
  input len_t  length_i,
  input line_t line_i,
  input logic  last_i
);

  // A stalled token word must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(length_i)
      && $stable(line_i) && $stable(last_i))
    else $error("stalled token word changed");

  // The end token always closes the run of its input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_END) |-> last_i)
    else $error("end token not marked last");

  // End and error tokens carry no text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((kind_i == KIND_END) || (kind_i == KIND_ERROR)) |-> (length_i == '0))
    else $error("end or error token with nonzero length");

  // Lines count from one and token kinds stay in their range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (line_i != '0) && (kind_i <= KIND_ERROR))
    else $error("token with line zero or kind out of range");

endmodule

bind source_tokenizer_unit stu_checker u_stu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (tok_o.valid),
  .out_ready_i (tok_o.ready),
  .kind_i      (tok_o.token_kind),
  .length_i    (tok_o.token_length),
  .line_i      (tok_o.line_number),
  .last_i      (tok_o.last_of_run)
);

>>> sim/tb.sv
// Testbench for source_tokenizer_unit: a directed opening and random source programs, checked token by token.
`timescale 1ns / 1ps

module tb import stu_pkg::*;;

  localparam kind_t TOK_ASSIGN = 6'd5;
  localparam kind_t TOK_EQ     = 6'd6;
  localparam kind_t TOK_BANG   = 6'd9;
  localparam kind_t TOK_NE     = 6'd10;
  localparam kind_t TOK_LT     = 6'd11;
  localparam kind_t TOK_LE     = 6'd12;
  localparam kind_t TOK_GT     = 6'd13;
  localparam kind_t TOK_GE     = 6'd14;
  localparam kind_t TOK_PLUS   = 6'd15;
  localparam kind_t TOK_INC    = 6'd16;
  localparam kind_t TOK_MINUS  = 6'd17;
  localparam kind_t TOK_DEC    = 6'd18;

  localparam int STALL_LIMIT = 1000;
  localparam int ITEM_TARGET = 1600;

  typedef enum logic [2:0] {SCAN_IDLE, SCAN_OP, SCAN_STR, SCAN_NUM, SCAN_WORD} scan_e;

  class token_scoreboard;
    scan_e      mode;
    logic       dot;
    len_t       run_len;
    line_t      cur_line;
    cand_t      kw_live;
    logic [2:0] held;
    tok_t       expected_q[$];
    tok_t       step_q[$];
    int         fails;

    function new();
      restart();
      fails = 0;
    endfunction

    static function string spelling(int k);
      case (k)
        0: return "void";
        1: return "bool";
        2: return "char";
        3: return "string";
        4: return "i32";
        5: return "i64";
        6: return "f32";
        7: return "f64";
        8: return "return";
        9: return "true";
        10: return "false";
        default: return "call";
      endcase
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit is_space(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function logic [7:0] op_text(logic [2:0] h);
      case (h)
        PEND_BANG: return "!";
        PEND_LT: return "<";
        PEND_GT: return ">";
        PEND_PLUS: return "+";
        PEND_MINUS: return "-";
        default: return "=";
      endcase
    endfunction

    function kind_t op_lone(logic [2:0] h);
      case (h)
        PEND_BANG: return TOK_BANG;
        PEND_LT: return TOK_LT;
        PEND_GT: return TOK_GT;
        PEND_PLUS: return TOK_PLUS;
        PEND_MINUS: return TOK_MINUS;
        default: return TOK_ASSIGN;
      endcase
    endfunction

    function kind_t op_double(logic [2:0] h);
      case (h)
        PEND_BANG: return TOK_NE;
        PEND_LT: return TOK_LE;
        PEND_GT: return TOK_GE;
        PEND_PLUS: return TOK_INC;
        PEND_MINUS: return TOK_DEC;
        default: return TOK_EQ;
      endcase
    endfunction

    function void clear_token();
      mode    = SCAN_IDLE;
      dot     = 1'b0;
      run_len = '0;
      kw_live = '1;
      held    = '0;
    endfunction

    function void restart();
      clear_token();
      cur_line = line_t'(1);
    endfunction

    function void emit_token(kind_t k, len_t l);
      tok_t t;
      t.kind   = k;
      t.length = l;
      t.line   = cur_line;
      t.last   = 1'b0;
      step_q = {step_q, t};
    endfunction

    function void bump_len();
      if (run_len != LEN_MAX) run_len++;
    endfunction

    function cand_t narrow(cand_t live, len_t pos, logic [7:0] b);
      cand_t keep;
      string s;
      keep = '0;
      if (pos < len_t'(KW_MAX_LEN)) begin
        for (int k = 0; k < KW_COUNT; k++) begin
          s = spelling(k);
          if (live[k] && int'(pos) < s.len() && s[int'(pos)] == b) keep[k] = 1'b1;
        end
      end
      return keep;
    endfunction

    function void close_word();
      len_t  l;
      kind_t k;
      bit    found;
      string s;
      if (mode == SCAN_NUM) begin
        l = run_len;
        if (dot && held[0] && l != LEN_MAX) l++;
        emit_token(dot ? KIND_POINT : KIND_INT, l);
      end else begin
        k = KIND_IDENT;
        found = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
          s = spelling(i);
          if (!found && kw_live[i] && int'(run_len) == s.len()) begin
            k = KIND_KW0 + kind_t'(i);
            found = 1'b1;
          end
        end
        emit_token(k, run_len);
      end
    endfunction

    function void scan_fresh(logic [7:0] b);
      clear_token();
      case (b)
        ",": emit_token(KIND_COMMA, len_t'(1));
        "{": emit_token(KIND_LBRACE, len_t'(1));
        "}": emit_token(KIND_RBRACE, len_t'(1));
        "(": emit_token(KIND_LPAREN, len_t'(1));
        ")": emit_token(KIND_RPAREN, len_t'(1));
        ":": emit_token(KIND_COLON, len_t'(1));
        ";": emit_token(KIND_SEMI, len_t'(1));
        "*": emit_token(KIND_STAR, len_t'(1));
        "/": emit_token(KIND_SLASH, len_t'(1));
        "=": begin mode = SCAN_OP; held = PEND_EQ; end
        "!": begin mode = SCAN_OP; held = PEND_BANG; end
        "<": begin mode = SCAN_OP; held = PEND_LT; end
        ">": begin mode = SCAN_OP; held = PEND_GT; end
        "+": begin mode = SCAN_OP; held = PEND_PLUS; end
        "-": begin mode = SCAN_OP; held = PEND_MINUS; end
        "\"": begin mode = SCAN_STR; run_len = len_t'(1); end
        default: begin
          if (is_space(b)) begin
            if (b == "\n" && cur_line != LINE_MAX) cur_line++;
          end else if (is_digit(b)) begin
            mode    = SCAN_NUM;
            run_len = len_t'(1);
          end else if (is_alpha(b)) begin
            mode    = SCAN_WORD;
            kw_live = narrow('1, '0, b);
            run_len = len_t'(1);
          end else begin
            emit_token(KIND_ERROR, '0);
          end
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic eoi);
      step_q.delete();
      if (eoi) begin
        case (mode)
          SCAN_OP: emit_token(op_lone(held), len_t'(1));
          SCAN_STR: emit_token(KIND_ERROR, '0);
          SCAN_NUM, SCAN_WORD: close_word();
          default: ;
        endcase
        emit_token(KIND_END, '0);
        restart();
      end else begin
        case (mode)
          SCAN_OP: begin
            if (b == op_text(held)) begin
              emit_token(op_double(held), len_t'(2));
              clear_token();
            end else begin
              emit_token(op_lone(held), len_t'(1));
              scan_fresh(b);
            end
          end
          SCAN_STR: begin
            bump_len();
            if (b == "\"") begin
              emit_token(KIND_STRING, run_len);
              clear_token();
            end
          end
          SCAN_NUM: begin
            if (is_digit(b)) begin
              bump_len();
              held = '0;
            end else if (b == "." && !dot) begin
              bump_len();
              dot  = 1'b1;
              held = 3'd1;
            end else begin
              close_word();
              scan_fresh(b);
            end
          end
          SCAN_WORD: begin
            if (is_alpha(b) || is_digit(b) || b == "_") begin
              kw_live = narrow(kw_live, run_len, b);
              bump_len();
            end else begin
              close_word();
              scan_fresh(b);
            end
          end
          default: scan_fresh(b);
        endcase
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      expected_q = {expected_q, step_q};
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (expected_q.size() == 0) begin
        $error("Unexpected token: kind %0d, length %0d, line %0d",
               got.kind, got.length, got.line);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
        fails++;
      end
      if (got.length !== want.length) begin
        $error("token_length: expected %0d, got %0d", want.length, got.length);
        fails++;
      end
      if (got.line !== want.line) begin
        $error("line_number: expected %0d, got %0d", want.line, got.line);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  bit              steady;
  int              sent;
  int              quiet;
  token_scoreboard sb;

  stu_chr_if chr ();
  stu_tok_if tok ();

  source_tokenizer_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .chr_i  (chr.sink),
    .tok_o  (tok.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] digit_byte();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] letter_byte();
    return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 3))
      0: return digit_byte();
      1: return "_";
      default: return letter_byte();
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == "\"");
    return b;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 5))
      0: return "\t";
      1: return "\n";
      2: return 8'd11;
      3: return 8'd12;
      4: return "\r";
      default: return " ";
    endcase
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eoi);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      chr.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chr.valid        <= 1'b1;
    chr.byte_in      <= b;
    chr.end_of_input <= eoi;
    @(posedge clk);
    while (!chr.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_lexeme();
    string s;
    int    n;
    case ($urandom_range(0, 10))
      0, 1: begin
        s = token_scoreboard::spelling($urandom_range(0, KW_COUNT - 1));
        n = $urandom_range(0, 1) ? s.len() : $urandom_range(1, s.len());
        for (int i = 0; i < n; i++) send_word(s[i], 1'b0);
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) send_word(word_byte(), 1'b0);
      end
      2: begin
        send_word(letter_byte(), 1'b0);
        repeat ($urandom_range(0, 7)) send_word(word_byte(), 1'b0);
      end
      3: repeat ($urandom_range(1, 6)) send_word(digit_byte(), 1'b0);
      4: begin
        repeat ($urandom_range(1, 4)) send_word(digit_byte(), 1'b0);
        send_word(".", 1'b0);
        repeat ($urandom_range(0, 3)) send_word(digit_byte(), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          send_word(".", 1'b0);
          send_word(digit_byte(), 1'b0);
        end
      end
      5: begin
        send_word("\"", 1'b0);
        repeat ($urandom_range(0, 10)) send_word($urandom_range(0, 3) ? text_byte() : "\n", 1'b0);
        send_word("\"", 1'b0);
      end
      6, 7: begin
        s = ",{}():;*/=!<>+-";
        send_word(s[$urandom_range(0, s.len() - 1)], 1'b0);
      end
      8: begin
        s = "=!<>+-";
        n = $urandom_range(0, s.len() - 1);
        send_word(s[n], 1'b0);
        if ($urandom_range(0, 2)) send_word(n < 4 ? "=" : s[n], 1'b0);
        else send_word(s[$urandom_range(0, s.len() - 1)], 1'b0);
      end
      9: send_word(8'($urandom_range(0, 255)), 1'b0);
      default: send_word($urandom_range(0, 1) ? "." : "_", 1'b0);
    endcase
  endtask

  task automatic send_program();
    steady = ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(3, 30)) begin
      send_lexeme();
      if ($urandom_range(0, 1)) send_word(space_byte(), 1'b0);
    end
    if ($urandom_range(0, 5) == 0) begin
      send_word("\"", 1'b0);
      repeat ($urandom_range(0, 3)) send_word(text_byte(), 1'b0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int stall;
    tok.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        tok.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tok.ready <= 1'b1;
      @(posedge clk);
      while (!tok.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tok_t seen;
    if (rst_n) begin
      if (chr.valid && chr.ready) sb.note_input(chr.byte_in, chr.end_of_input);
      if (tok.valid && tok.ready) begin
        seen.kind   = tok.token_kind;
        seen.length = tok.token_length;
        seen.line   = tok.line_number;
        seen.last   = tok.last_of_run;
        sb.check_token(seen);
      end
      if ((chr.valid && chr.ready) || (tok.valid && tok.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("** source_tokenizer_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] opening[$];
    sb     = new();
    steady = 1'b0;
    sent   = 0;
    quiet  = 0;
    rst_n  = 1'b0;
    chr.valid        <= 1'b0;
    chr.byte_in      <= '0;
    chr.end_of_input <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Byte extremes, a string holding 0xFF and a newline, a second dot,
    // a trailing dot, a keyword ended by punctuation and a flush at end of input.
    opening = '{8'h00, 8'hFF, "\"", 8'hFF, "\n", "\"", "1", ".", "2", ".",
                "7", ".", "\n", "_", "f", "6", "4", ";", "=", "=", "!", "a"};
    foreach (opening[i]) send_word(opening[i], 1'b0);
    send_word(8'hFF, 1'b1);

    while (sent < ITEM_TARGET) send_program();
    steady = 1'b0;

    chr.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("** source_tokenizer_unit: PASSED **");
    end else begin
      $display("** source_tokenizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
